// File: src/ngga_pkg.sv
// Package for the GGA time-field extractor.
// Holds the line limits, character codes, field numbers and the
// controller/datapath command and status types. Depends on nothing.
package ngga_pkg;

  // Line and capture limits.
  localparam int MAX_LINE    = 80;
  localparam int CAPTURE_LEN = 12;
  localparam int HDR_LEN     = 6;

  // Derived widths.
  localparam int BYTE_W = 8;
  localparam int COL_W  = $clog2(MAX_LINE + 1);
  localparam int TLEN_W = $clog2(CAPTURE_LEN + 1);
  localparam int IDX_W  = $clog2(CAPTURE_LEN);
  localparam int HLEN_W = $clog2(HDR_LEN + 1);
  localparam int FLD_W  = 2;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;

  // Field numbers; the last one stands for every field beyond the time field.
  localparam logic [FLD_W-1:0] FIELD_HDR  = 2'd0;
  localparam logic [FLD_W-1:0] FIELD_TIME = 2'd1;
  localparam logic [FLD_W-1:0] FIELD_REST = 2'd2;

  // Controller states.
  typedef enum logic [0:0] {
    ST_RUN,
    ST_EMIT
  } ngga_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;   // process one ordinary (non-newline) character
    logic line_clear;  // start a new line
    logic load_char;   // load the next captured character into the output
    logic load_nl;     // load the closing newline into the output
  } ngga_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_nl;       // incoming byte is a newline
    logic hdr_ok;      // full header seen and matched
    logic emit_done;   // every captured character has been loaded
    logic out_free;    // output register can take a beat this cycle
  } ngga_sts_t;

  // Expected header character at a given position.
  function automatic logic [BYTE_W-1:0] hdr_char(input logic [HLEN_W-1:0] pos);
    logic [BYTE_W-1:0] ch;
    unique case (pos)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = CH_G;
      3'd2:    ch = CH_N;
      3'd3:    ch = CH_G;
      3'd4:    ch = CH_G;
      3'd5:    ch = CH_A;
      default: ch = CH_A;
    endcase
    return ch;
  endfunction

endpackage

// File: src/ngga_if.sv
// Valid/ready channel interfaces for the GGA time-field extractor.
// Uses ngga_pkg for the byte width.

// Input channel: one received character per beat.
interface ngga_in_if;
  logic                          valid;
  logic                          ready;
  logic [ngga_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: one time character or the closing newline per beat.
interface ngga_out_if;
  logic                          valid;
  logic                          ready;
  logic [ngga_pkg::BYTE_W-1:0]   tx_byte;
  logic                          last;

  modport source (output valid, output tx_byte, output last, input ready);
  modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

// File: src/nmea_gga_time_field_extractor.sv
// GGA time-field extractor: takes one received character per beat and,
// for each newline-terminated line whose first field starts with "$GNGGA",
// sends the first CAPTURE_LEN (12) characters of the time field followed by
// a newline beat flagged last. While a line is read, one byte is taken every
// cycle. A newline that ends a matching line starts an emit burst of
// N + 1 result beats (N captured characters, 0 to 12), one per cycle while
// the sink is ready, set by the single output register; input is paused
// for that burst. A non-matching line ends at its newline with no result.
// Characters past the first MAX_LINE (80) of a line are ignored.
// Depends on ngga_pkg, ngga_if, ngga_ctrl and ngga_dp.
module nmea_gga_time_field_extractor (
  input  logic       clk,
  input  logic       rst_n,
  ngga_in_if.sink    in_ch,
  ngga_out_if.source out_ch
);

  ngga_pkg::ngga_cmd_t cmd;
  ngga_pkg::ngga_sts_t sts;

  // Controller: line intake and emit sequencing.
  ngga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: line state, capture buffer and output register.
  ngga_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.rx_byte),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.tx_byte),
    .out_last  (out_ch.last),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: src/ngga_ctrl.sv
// Controller of the GGA time-field extractor.
// Sequences line intake and the emit burst; uses ngga_pkg types.
module ngga_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ngga_pkg::ngga_sts_t sts,
  output ngga_pkg::ngga_cmd_t cmd
);

  ngga_pkg::ngga_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ngga_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a newline ending a matching line starts the emit burst,
  // which ends once the closing newline is loaded.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ngga_pkg::ST_RUN: begin
        if (in_valid && sts.is_nl && sts.hdr_ok) begin
          state_nxt = ngga_pkg::ST_EMIT;
        end
      end
      ngga_pkg::ST_EMIT: begin
        if (sts.out_free && sts.emit_done) begin
          state_nxt = ngga_pkg::ST_RUN;
        end
      end
      default: state_nxt = ngga_pkg::ST_RUN;
    endcase
  end

  // Outputs: input is taken only while reading a line.
  always_comb begin
    in_ready       = 1'b0;
    cmd.take_byte  = 1'b0;
    cmd.line_clear = 1'b0;
    cmd.load_char  = 1'b0;
    cmd.load_nl    = 1'b0;
    unique case (state_r)
      ngga_pkg::ST_RUN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!sts.is_nl) begin
            cmd.take_byte = 1'b1;
          end else if (!sts.hdr_ok) begin
            cmd.line_clear = 1'b1;
          end
        end
      end
      ngga_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          if (sts.emit_done) begin
            cmd.load_nl    = 1'b1;
            cmd.line_clear = 1'b1;
          end else begin
            cmd.load_char = 1'b1;
          end
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// File: src/ngga_dp.sv
// Datapath of the GGA time-field extractor.
// Holds the line state, the captured time characters and the output
// register; driven by ngga_ctrl commands, uses ngga_pkg.
module ngga_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ngga_pkg::BYTE_W-1:0]  in_byte,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [ngga_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last,
  input  ngga_pkg::ngga_cmd_t          cmd,
  output ngga_pkg::ngga_sts_t          sts
);

  logic [ngga_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [ngga_pkg::FLD_W-1:0]   field_r, field_nxt;
  logic                         match_r, match_nxt;
  logic [ngga_pkg::HLEN_W-1:0]  hlen_r, hlen_nxt;
  logic [ngga_pkg::TLEN_W-1:0]  tlen_r, tlen_nxt;
  logic [ngga_pkg::TLEN_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic                         wr_en;
  logic [ngga_pkg::BYTE_W-1:0]  time_chars [ngga_pkg::CAPTURE_LEN];
  logic                         out_valid_r;
  logic [ngga_pkg::BYTE_W-1:0]  out_byte_r;
  logic                         out_last_r;
  logic                         out_load;

  // Status toward the controller.
  assign sts.is_nl     = (in_byte == ngga_pkg::CH_NL);
  assign sts.hdr_ok    = match_r && (hlen_r == ngga_pkg::HLEN_W'(ngga_pkg::HDR_LEN));
  assign sts.emit_done = (emit_idx_r == tlen_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Line state update for one ordinary character, one emitted character, or a fresh line.
  always_comb begin
    col_nxt      = col_r;
    field_nxt    = field_r;
    match_nxt    = match_r;
    hlen_nxt     = hlen_r;
    tlen_nxt     = tlen_r;
    emit_idx_nxt = emit_idx_r;
    wr_en        = 1'b0;
    if (cmd.line_clear) begin
      col_nxt      = '0;
      field_nxt    = ngga_pkg::FIELD_HDR;
      match_nxt    = 1'b1;
      hlen_nxt     = '0;
      tlen_nxt     = '0;
      emit_idx_nxt = '0;
    end else if (cmd.load_char) begin
      emit_idx_nxt = emit_idx_r + 1'b1;
    end else if (cmd.take_byte && (col_r < ngga_pkg::COL_W'(ngga_pkg::MAX_LINE))) begin
      col_nxt = col_r + 1'b1;
      if (in_byte == ngga_pkg::CH_COMMA) begin
        // A comma moves on to the next field; a short header fails here.
        if (field_r != ngga_pkg::FIELD_REST) begin
          if (field_r == ngga_pkg::FIELD_HDR &&
              hlen_r < ngga_pkg::HLEN_W'(ngga_pkg::HDR_LEN)) begin
            match_nxt = 1'b0;
          end
          field_nxt = field_r + 1'b1;
        end
      end else if (field_r == ngga_pkg::FIELD_HDR) begin
        // Only the first six header characters are checked.
        if (hlen_r < ngga_pkg::HLEN_W'(ngga_pkg::HDR_LEN)) begin
          if (in_byte != ngga_pkg::hdr_char(hlen_r)) begin
            match_nxt = 1'b0;
          end
          hlen_nxt = hlen_r + 1'b1;
        end
      end else if (field_r == ngga_pkg::FIELD_TIME) begin
        // Capture saturates at the buffer length.
        if (tlen_r < ngga_pkg::TLEN_W'(ngga_pkg::CAPTURE_LEN)) begin
          wr_en    = 1'b1;
          tlen_nxt = tlen_r + 1'b1;
        end
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      field_r    <= ngga_pkg::FIELD_HDR;
      match_r    <= 1'b1;
      hlen_r     <= '0;
      tlen_r     <= '0;
      emit_idx_r <= '0;
    end else begin
      col_r      <= col_nxt;
      field_r    <= field_nxt;
      match_r    <= match_nxt;
      hlen_r     <= hlen_nxt;
      tlen_r     <= tlen_nxt;
      emit_idx_r <= emit_idx_nxt;
    end
  end

  // Captured time characters.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_chars[tlen_r[ngga_pkg::IDX_W-1:0]] <= in_byte;
    end
  end

  // Output register: holds one beat until the sink takes it.
  assign out_load = cmd.load_char || cmd.load_nl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_nl) begin
      out_byte_r <= ngga_pkg::CH_NL;
      out_last_r <= 1'b1;
    end else if (cmd.load_char) begin
      out_byte_r <= time_chars[emit_idx_r[ngga_pkg::IDX_W-1:0]];
      out_last_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// File: src/ngga_checker.sv
// Port-level checks for the GGA time-field extractor, bound to the top level.
// Uses ngga_pkg character codes.
module ngga_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [ngga_pkg::BYTE_W-1:0] rx_byte,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ngga_pkg::BYTE_W-1:0] tx_byte,
  input logic                        last
);

  // The closing beat always carries a newline.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last |-> tx_byte == ngga_pkg::CH_NL)
    else $error("closing beat is not a newline");

  // A time character can never be a newline or a comma.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> tx_byte != ngga_pkg::CH_NL && tx_byte != ngga_pkg::CH_COMMA)
    else $error("time beat carries a separator");

  // Input is held off while time characters are still being sent.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !in_ready)
    else $error("input taken during an emit burst");

  // An ordinary character never produces a result beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && rx_byte != ngga_pkg::CH_NL && !out_valid |=> !out_valid)
    else $error("result beat without a newline");

endmodule

bind nmea_gga_time_field_extractor ngga_checker u_ngga_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .rx_byte   (in_ch.rx_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .tx_byte   (out_ch.tx_byte),
  .last      (out_ch.last)
);

// File: test/ngga_time_checker.sv
// Checker for the GGA time-field extractor: watches both channels, predicts
// the emitted time-field beats and compares them in order.
// Depends on ngga_pkg for the line limits and character codes.
module ngga_time_checker
  import ngga_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              out_last,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
  } time_beat_t;

  localparam logic [BYTE_W-1:0] GGA_TAG [HDR_LEN] = '{
    CH_DOLLAR, CH_G, CH_N, CH_G, CH_G, CH_A
  };

  // Shadow line state.
  logic [COL_W-1:0]  col_seen;
  logic [FLD_W-1:0]  field_at;
  logic              tag_ok;
  logic [HLEN_W-1:0] tag_len;
  logic [BYTE_W-1:0] time_buf [CAPTURE_LEN];
  logic [TLEN_W-1:0] time_cnt;

  time_beat_t time_beats_due [$];

  task automatic restart_line();
    col_seen = '0;
    field_at = FIELD_HDR;
    tag_ok   = 1'b1;
    tag_len  = '0;
    time_cnt = '0;
  endtask

  // Advance the shadow line state by one received character and queue the
  // beats that a newline releases.
  task automatic gga_line_step(input logic [BYTE_W-1:0] ch);
    int k;
    if (ch == CH_NL) begin
      if (tag_ok && tag_len == HDR_LEN) begin
        for (k = 0; k < time_cnt; k++)
          time_beats_due.push_back('{tx_byte: time_buf[k], last: 1'b0});
        time_beats_due.push_back('{tx_byte: CH_NL, last: 1'b1});
      end
      restart_line();
    end else if (col_seen < MAX_LINE) begin
      col_seen++;
      if (ch == CH_COMMA) begin
        if (field_at != FIELD_REST) begin
          if (field_at == FIELD_HDR && tag_len < HDR_LEN)
            tag_ok = 1'b0;
          field_at++;
        end
      end else if (field_at == FIELD_HDR) begin
        if (tag_len < HDR_LEN) begin
          if (ch != GGA_TAG[tag_len])
            tag_ok = 1'b0;
          tag_len++;
        end
      end else if (field_at == FIELD_TIME) begin
        if (time_cnt < CAPTURE_LEN) begin
          time_buf[time_cnt] = ch;
          time_cnt++;
        end
      end
    end
  endtask

  // Result beats are checked before the input beat of the same edge is
  // predicted; a registered output can never stem from that input.
  always @(posedge clk) begin
    time_beat_t due;
    if (!rst_n) begin
      restart_line();
      time_beats_due.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (time_beats_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got tx_byte=%h last=%b",
                   $time, out_byte, out_last);
          fail_count <= fail_count + 1;
        end else begin
          due = time_beats_due.pop_front();
          if (out_byte !== due.tx_byte || out_last !== due.last) begin
            $display("%0t: beat mismatch, expected tx_byte=%h last=%b, got tx_byte=%h last=%b",
                     $time, due.tx_byte, due.last, out_byte, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        gga_line_step(in_byte);
    end
    pending <= time_beats_due.size();
  end

endmodule

// File: test/tb_nmea_gga_time_field_extractor.sv
// Testbench top for the GGA time-field extractor: drives directed and random
// NMEA-like lines with random idling, and reports the checker's verdict.
// Depends on ngga_pkg, ngga_if, the extractor RTL and ngga_time_checker.
module tb_nmea_gga_time_field_extractor;
  import ngga_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   beats_sent;

  ngga_in_if  in_ch ();
  ngga_out_if out_ch ();

  nmea_gga_time_field_extractor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ngga_time_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.rx_byte),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.tx_byte),
    .out_last   (out_ch.last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver side: random back-pressure.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Random character that is neither a comma nor a newline.
  function automatic logic [BYTE_W-1:0] rand_plain();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255)); while (b == CH_COMMA || b == CH_NL);
    return b;
  endfunction

  // Send one input beat, with random idle cycles ahead of it.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  // Hold the sender off until every released beat has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A GGA line with random content; some have a broken or odd header.
  task automatic send_gga_line();
    int    mode, j, n, pos, nrest;
    string tag;
    tag  = "$GNGGA";
    mode = $urandom_range(99);
    pos  = $urandom_range(HDR_LEN - 1);
    if (mode < 10) begin
      // Short header.
      n = $urandom_range(HDR_LEN - 1);
      for (j = 0; j < n; j++) send_byte(tag[j]);
    end else begin
      for (j = 0; j < HDR_LEN; j++) begin
        if (mode < 25 && j == pos) send_byte(rand_plain());
        else send_byte(tag[j]);
      end
      // Extra characters in the first field are not checked.
      if (mode >= 25 && mode < 33)
        repeat ($urandom_range(1, 3)) send_byte(rand_plain());
    end
    if ($urandom_range(99) >= 6) begin
      send_byte(CH_COMMA);
      n = ($urandom_range(99) < 12) ? $urandom_range(CAPTURE_LEN + 1, CAPTURE_LEN + 4)
                                    : $urandom_range(0, CAPTURE_LEN);
      for (j = 0; j < n; j++) begin
        if ($urandom_range(99) < 70)
          send_byte(BYTE_W'((j == 6) ? "." : ("0" + $urandom_range(9))));
        else send_byte(rand_plain());
      end
      nrest = $urandom_range(0, 3);
      repeat (nrest) begin
        send_byte(CH_COMMA);
        repeat ($urandom_range(0, 4)) send_byte(rand_plain());
      end
    end
    send_byte(CH_NL);
  endtask

  // Noise lines: raw bytes, or a line that runs past the column limit.
  task automatic send_noise_line();
    int f, j;
    if ($urandom_range(99) < 30) begin
      // The comma lands near the column limit; past it the line is ignored.
      send_text("$GNGGA");
      f = $urandom_range(MAX_LINE - 10, MAX_LINE - 4);
      for (j = 0; j < f; j++) send_byte(rand_plain());
      send_byte(CH_COMMA);
      repeat ($urandom_range(1, 8)) send_byte(BYTE_W'("0" + $urandom_range(9)));
    end else begin
      repeat ($urandom_range(1, 20)) send_byte(BYTE_W'($urandom_range(255)));
    end
    send_byte(CH_NL);
  endtask

  // Stimulus and verdict.
  initial begin
    int phase_idle  [4];
    int phase_stall [4];
    int ph, start_cnt, guard;
    phase_idle  = '{0, 58, 0, 8};
    phase_stall = '{0, 0, 58, 8};
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    beats_sent     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: normal, short header, missing and empty time field,
    // long first field with a long time field, foreign talker, odd bytes.
    send_text("$GNGGA,123519.00\n");
    send_text("$GNG\n");
    send_text("$GNGGA\n");
    send_text("$GNGGA,,1\n");
    send_text("$GNGGAXY,0123456789ABCDE,Z\n");
    send_text("$GPGGA,1\n");
    send_text("$GNGGA,");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0D);
    send_byte(CH_NL);
    // Long line: the comma after the column limit is ignored.
    send_text("$GNGGA");
    repeat (MAX_LINE - HDR_LEN) send_byte("Z");
    send_text(",12345\n");
    drain_results();

    // Random lines in phases of sender idling and receiver stalling.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      start_cnt      = beats_sent;
      while (beats_sent - start_cnt < 60) begin
        if ($urandom_range(99) < 75) send_gga_line();
        else send_noise_line();
        if ($urandom_range(99) < 5) drain_results();
      end
      drain_results();
    end

    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (pending != 0)
      $display("%0t: %0d expected beats never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
